/* hw/rtl/dgna_pkg.sv */
// shared widths, codes and register reset values for the dragonfly node allocator
`timescale 1ns / 1ps

package dgna_pkg;

  localparam int FUNC_W = 1;
  localparam int NODE_W = 8;
  localparam int JOB_W  = 7;
  localparam int CFG_W  = 5;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_SET   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTERS_PER_GROUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_PER_ROUTER  = 2'd2;

  localparam logic [CFG_W-1:0] RST_GROUPS_IN_USE     = 5'd16;
  localparam logic [CFG_W-1:0] RST_ROUTERS_PER_GROUP = 5'd4;
  localparam logic [CFG_W-1:0] RST_NODES_PER_ROUTER  = 5'd4;

endpackage

/* hw/rtl/dragonfly_group_node_allocator.sv */
// dragonfly group first-fit node allocator: free map memory, scan sequencer and emit register
// set-node request: written to the free map, no result
// allocate request: count/group scan of the free map (one memory read per cycle), then
//   an emit pass that reads and checks each node examined and waits on output stalls
// the free map read sets the rate: no request is taken until the previous allocate finishes
// reset: synchronous; a clearing pass over all GROUPS*GROUP_NODES slots marks every node free,
//   during which no request is taken (configuration writes are taken)
`timescale 1ns / 1ps

module dragonfly_group_node_allocator #(
  parameter int GROUPS      = 16,
  parameter int GROUP_NODES = 16,
  parameter int MAX_JOB     = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dgna_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dgna_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dgna_pkg::FUNC_W-1:0]    func,
  input  logic [dgna_pkg::NODE_W-1:0]    node,
  input  logic                          node_free,
  input  logic [dgna_pkg::JOB_W-1:0]     job_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dgna_pkg::NODE_W-1:0]    node_id,
  output logic                          ok,
  output logic                          last
);

  localparam int NODE_SLOTS = GROUPS * GROUP_NODES;
  localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CNT_W = $clog2(NODE_SLOTS + 1);
  localparam int NPG_W = $clog2(GROUP_NODES + 1);
  localparam int NG_W  = $clog2(GROUPS + 1);
  localparam int JOB_W = dgna_pkg::JOB_W;
  localparam int CMP_W = (CNT_W > JOB_W) ? CNT_W : JOB_W;
  localparam int NW    = (CNT_W > dgna_pkg::NODE_W) ? CNT_W : dgna_pkg::NODE_W + 1;
  localparam int PROD_W = 2 * dgna_pkg::CFG_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FAIL   = 3'd4;
  localparam logic [2:0] S_EM_RD  = 3'd5;
  localparam logic [2:0] S_EM_CHK = 3'd6;

  logic [2:0] state;

  logic [dgna_pkg::CFG_W-1:0] groups_in_use;
  logic [dgna_pkg::CFG_W-1:0] routers_per_group;
  logic [dgna_pkg::CFG_W-1:0] nodes_per_router;

  // free map memory
  logic mem [NODE_SLOTS];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_bit;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_bit;

  logic [IDX_W-1:0] clr_addr;

  // machine geometry
  logic [PROD_W-1:0] prod;
  logic [NPG_W-1:0]  npg;
  logic [NG_W-1:0]   ngroups;
  logic [CNT_W-1:0]  total;

  // scan state
  logic [CNT_W-1:0] scan_addr;
  logic             pend;
  logic [CNT_W-1:0] freecnt;
  logic [NPG_W-1:0] gcnt;
  logic [NPG_W-1:0] lpos;
  logic [CNT_W-1:0] gbase;
  logic             found;
  logic [CNT_W-1:0] fbase;
  logic [JOB_W-1:0] job;

  // emit state
  logic [CNT_W-1:0] e_addr;
  logic             asc;
  logic [JOB_W-1:0] k;

  logic slot_free;
  logic out_load;
  logic is_last;
  logic [CNT_W-1:0] e_step;

  assign prod    = PROD_W'(routers_per_group) * PROD_W'(nodes_per_router);
  assign npg     = (prod > PROD_W'(GROUP_NODES)) ? NPG_W'(GROUP_NODES) : NPG_W'(prod);
  assign ngroups = (int'(groups_in_use) > GROUPS) ? NG_W'(GROUPS) : NG_W'(groups_in_use);
  assign total   = CNT_W'(CNT_W'(npg) * CNT_W'(ngroups));

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign is_last   = (JOB_W'(k + 1'b1) == job);
  assign e_step    = asc ? CNT_W'(e_addr + 1'b1) : CNT_W'(e_addr - 1'b1);
  assign out_load  = slot_free && ((state == S_FAIL) || (state == S_EM_CHK && rd_bit));

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_bit  = 1'b1;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (in_valid && in_ready && func == dgna_pkg::FUNC_SET &&
                 NW'(node) < NW'(NODE_SLOTS)) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(node);
      wr_bit  = node_free;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = e_addr[IDX_W-1:0];
    if (state == S_SCAN && scan_addr < total) begin
      rd_en   = 1'b1;
      rd_addr = scan_addr[IDX_W-1:0];
    end else if (state == S_EM_RD) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use     <= dgna_pkg::RST_GROUPS_IN_USE;
      routers_per_group <= dgna_pkg::RST_ROUTERS_PER_GROUP;
      nodes_per_router  <= dgna_pkg::RST_NODES_PER_ROUTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dgna_pkg::CFG_GROUPS_IN_USE:     groups_in_use     <= cfg_data;
        dgna_pkg::CFG_ROUTERS_PER_GROUP: routers_per_group <= cfg_data;
        dgna_pkg::CFG_NODES_PER_ROUTER:  nodes_per_router  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= IDX_W'(clr_addr + 1'b1);
          if (clr_addr == IDX_W'(NODE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && func == dgna_pkg::FUNC_ALLOC) begin
            job       <= job_size;
            scan_addr <= '0;
            pend      <= 1'b0;
            freecnt   <= '0;
            gcnt      <= '0;
            lpos      <= '0;
            gbase     <= '0;
            found     <= 1'b0;
            fbase     <= '0;
            k         <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one bit issued and one bit counted each cycle
          if (pend) begin
            freecnt <= CNT_W'(freecnt + CNT_W'(rd_bit));
            if (NPG_W'(lpos + 1'b1) == npg) begin
              if (!found &&
                  (CMP_W'(CMP_W'(gcnt) + CMP_W'(rd_bit)) >= CMP_W'(job))) begin
                found <= 1'b1;
                fbase <= gbase;
              end
              gcnt  <= '0;
              lpos  <= '0;
              gbase <= CNT_W'(gbase + CNT_W'(npg));
            end else begin
              gcnt <= NPG_W'(gcnt + NPG_W'(rd_bit));
              lpos <= NPG_W'(lpos + 1'b1);
            end
          end
          if (scan_addr < total) begin
            scan_addr <= CNT_W'(scan_addr + 1'b1);
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if ((CMP_W'(job) > CMP_W'(MAX_JOB)) || (CMP_W'(freecnt) < CMP_W'(job))) begin
            state <= S_FAIL;
          end else if (job == '0) begin
            state <= S_IDLE;
          end else if (CMP_W'(job) <= CMP_W'(npg)) begin
            // first fitting group, else leftmost free nodes of the machine
            asc    <= 1'b1;
            e_addr <= found ? fbase : '0;
            state  <= S_EM_RD;
          end else begin
            asc    <= 1'b0;
            e_addr <= CNT_W'(total - 1'b1);
            state  <= S_EM_RD;
          end
        end
        S_FAIL: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        S_EM_RD: begin
          state <= S_EM_CHK;
        end
        S_EM_CHK: begin
          if (rd_bit) begin
            if (slot_free) begin
              k <= JOB_W'(k + 1'b1);
              if (is_last) begin
                state <= S_IDLE;
              end else begin
                e_addr <= e_step;
                state  <= S_EM_RD;
              end
            end
          end else begin
            e_addr <= e_step;
            state  <= S_EM_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_FAIL) begin
        node_id <= '0;
        ok      <= 1'b0;
        last    <= 1'b1;
      end else begin
        node_id <= dgna_pkg::NODE_W'(e_addr);
        ok      <= 1'b1;
        last    <= is_last;
      end
    end
  end

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> last)
    else $error("failure result without last mark");

  a_busy_after_alloc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == dgna_pkg::FUNC_ALLOC) |=> !in_ready)
    else $error("ready right after an allocate transfer");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_CHK) |-> (k < job))
    else $error("emit pass past the job size");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!out_valid && !in_ready))
    else $error("activity during clearing pass");

endmodule

/* sim/dgna_grant_checker.sv */
// checker for the dragonfly node allocator: tracks the free map, predicts node grants, compares
`timescale 1ns / 1ps

module dgna_grant_checker
  import dgna_pkg::*;
#(
  parameter int GROUPS      = 16,
  parameter int GROUP_NODES = 16,
  parameter int MAX_JOB     = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [FUNC_W-1:0]    func,
  input  logic [NODE_W-1:0]    node,
  input  logic                 node_free,
  input  logic [JOB_W-1:0]     job_size,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [NODE_W-1:0]    node_id,
  input  logic                 ok,
  input  logic                 last,
  output int                   fail_count,
  output int                   pending
);

  localparam int NODE_SLOTS = GROUPS * GROUP_NODES;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic              ok;
    logic              last;
  } grant_t;

  grant_t grant_q[$];
  bit free_bits [NODE_SLOTS];
  logic [CFG_W-1:0] groups_cfg, routers_cfg, nodes_cfg;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void push_grant(int id, bit okv, bit lastv);
    grant_t g;
    g.node_id = id[NODE_W-1:0];
    g.ok = okv;
    g.last = lastv;
    grant_q.push_back(g);
  endfunction

  function automatic void predict_grants(int job_n);
    int npg, ngroups, total, freecnt, gfree, base, k;
    bit placed;
    npg = int'(routers_cfg) * int'(nodes_cfg);
    if (npg > GROUP_NODES) npg = GROUP_NODES;
    ngroups = int'(groups_cfg);
    if (ngroups > GROUPS) ngroups = GROUPS;
    total = npg * ngroups;
    freecnt = 0;
    for (int n = 0; n < total; n++) freecnt += free_bits[n];
    k = 0;
    placed = 1'b0;
    if (job_n > MAX_JOB || freecnt < job_n) begin
      push_grant(0, 1'b0, 1'b1);
    end else if (job_n == 0) begin
      // zero-size job succeeds silently
    end else if (job_n <= npg) begin
      for (int g = 0; g < ngroups && !placed; g++) begin
        base = g * npg;
        gfree = 0;
        for (int l = 0; l < npg; l++) gfree += free_bits[base + l];
        if (gfree >= job_n) begin
          placed = 1'b1;
          for (int l = 0; l < npg && k < job_n; l++) begin
            if (free_bits[base + l]) begin
              push_grant(base + l, 1'b1, (k + 1) == job_n);
              k++;
            end
          end
        end
      end
      // no single group fits: lowest free nodes of the machine
      if (!placed) begin
        for (int n = 0; n < total && k < job_n; n++) begin
          if (free_bits[n]) begin
            push_grant(n, 1'b1, (k + 1) == job_n);
            k++;
          end
        end
      end
    end else begin
      for (int n = total - 1; n >= 0 && k < job_n; n--) begin
        if (free_bits[n]) begin
          push_grant(n, 1'b1, (k + 1) == job_n);
          k++;
        end
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      groups_cfg = RST_GROUPS_IN_USE;
      routers_cfg = RST_ROUTERS_PER_GROUP;
      nodes_cfg = RST_NODES_PER_ROUTER;
      foreach (free_bits[i]) free_bits[i] = 1'b1;
      grant_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROUPS_IN_USE:     groups_cfg = cfg_data;
          CFG_ROUTERS_PER_GROUP: routers_cfg = cfg_data;
          CFG_NODES_PER_ROUTER:  nodes_cfg = cfg_data;
          default: ;
        endcase
      end
      // results first, so a result cannot match an item taken on the same edge
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: node_id %0d ok %0d last %0d", node_id, ok, last);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (node_id !== want.node_id) begin
            $error("node_id mismatch: expected %0d, actual %0d", want.node_id, node_id);
            fail_count++;
          end
          if (ok !== want.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (func == FUNC_SET) begin
          if (int'(node) < NODE_SLOTS) free_bits[node] = node_free;
        end else begin
          predict_grants(int'(job_size));
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

/* sim/dragonfly_group_node_allocator_tb.sv */
// testbench top for the dragonfly node allocator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module dragonfly_group_node_allocator_tb;
  import dgna_pkg::*;

  localparam int GROUPS      = 16;
  localparam int GROUP_NODES = 16;
  localparam int MAX_JOB     = 64;
  localparam int SETTLE      = 700;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [FUNC_W-1:0]    func;
  logic [NODE_W-1:0]    node;
  logic                 node_free;
  logic [JOB_W-1:0]     job_size;
  logic                 out_valid;
  logic                 out_ready;
  logic [NODE_W-1:0]    node_id;
  logic                 ok;
  logic                 last;
  int                   fail_count;
  int                   pending;

  int  burst_left = 0;
  int  grp_nodes, mach_groups, mach_nodes;
  bit  hold_armed = 1'b0;

  int g_tab [8] = '{16, 1, 16, 3, 8, 5, 0, 16};
  int r_tab [8] = '{4, 1, 16, 5, 2, 3, 16, 31};
  int n_tab [8] = '{4, 1, 16, 3, 8, 2, 0, 1};

  dragonfly_group_node_allocator #(
    .GROUPS(GROUPS), .GROUP_NODES(GROUP_NODES), .MAX_JOB(MAX_JOB)
  ) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .node(node),
    .node_free(node_free), .job_size(job_size), .out_valid(out_valid),
    .out_ready(out_ready), .node_id(node_id), .ok(ok), .last(last)
  );

  dgna_grant_checker #(
    .GROUPS(GROUPS), .GROUP_NODES(GROUP_NODES), .MAX_JOB(MAX_JOB)
  ) grant_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .node(node),
    .node_free(node_free), .job_size(job_size), .out_valid(out_valid),
    .out_ready(out_ready), .node_id(node_id), .ok(ok), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_item(input logic [FUNC_W-1:0] f, input int nd, input bit nf,
                           input int js);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    node <= nd[NODE_W-1:0];
    node_free <= nf;
    job_size <= js[JOB_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_node(input int nd, input bit nf);
    send_item(FUNC_SET, nd, nf, $urandom_range(0, 127));
  endtask

  task automatic alloc_job(input int js);
    send_item(FUNC_ALLOC, $urandom_range(0, 255), $urandom_range(0, 1), js);
  endtask

  // stop offering, let every grant arrive, then let a silent scan finish
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_machine(input int g, input int r, input int n);
    cfg_write(CFG_GROUPS_IN_USE, g);
    cfg_write(CFG_ROUTERS_PER_GROUP, r);
    cfg_write(CFG_NODES_PER_ROUTER, n);
    cfg_we <= 1'b0;
    grp_nodes = (r * n > GROUP_NODES) ? GROUP_NODES : r * n;
    mach_groups = (g > GROUPS) ? GROUPS : g;
    mach_nodes = grp_nodes * mach_groups;
  endtask

  // receiver: runs of always-ready, light stall and heavy stall, plus one long hold
  initial begin
    int run_len, mode;
    out_ready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 40);
      mode = $urandom_range(0, 2);
      repeat (run_len) begin
        @(posedge clk);
        if (hold_armed && out_valid) begin
          hold_armed = 1'b0;
          out_ready <= 1'b0;
          repeat (3000) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int quota, sent, pick, busy_pct, js, nd, base;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_SET;
    node = '0;
    node_free = 1'b0;
    job_size = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_machine(RST_GROUPS_IN_USE, RST_ROUTERS_PER_GROUP, RST_NODES_PER_ROUTER);

    // full machine: group fits, large jobs from the top, zero and oversize jobs
    alloc_job(1);
    alloc_job(16);
    alloc_job(17);
    alloc_job(64);
    alloc_job(0);
    alloc_job(65);
    alloc_job(127);
    set_node(0, 1'b0);
    set_node(255, 1'b0);
    set_node(5, 1'b0);
    alloc_job(16);
    set_node(0, 1'b1);
    drain();
    set_machine(31, 31, 31);
    alloc_job(16);
    drain();
    set_machine(0, 4, 4);
    alloc_job(1);
    alloc_job(0);
    drain();
    // six-node machine in two groups: group fit, fallback, shortage
    set_machine(2, 1, 3);
    set_node(1, 1'b0);
    set_node(4, 1'b0);
    alloc_job(3);
    alloc_job(2);
    set_node(2, 1'b0);
    alloc_job(2);
    set_node(5, 1'b0);
    alloc_job(2);
    alloc_job(3);
    set_node(200, 1'b0);
    drain();
    set_machine(4, 0, 8);
    alloc_job(1);

    for (int p = 0; p < 10; p++) begin
      drain();
      if (p < 8) set_machine(g_tab[p], r_tab[p], n_tab[p]);
      else set_machine($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
      if (p == 0) hold_armed = 1'b1;
      quota = (mach_nodes == 0) ? 8 : 28;
      busy_pct = $urandom_range(40, 85);
      sent = 0;
      while (sent < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) js = $urandom_range(1, (grp_nodes > 0) ? grp_nodes : 1);
          else if (pick < 80) js = $urandom_range(grp_nodes + 1, MAX_JOB);
          else if (pick < 90) js = $urandom_range(1, 8);
          else if (pick < 95) js = 0;
          else js = $urandom_range(MAX_JOB + 1, 127);
          alloc_job(js);
          sent++;
        end else if (pick < 80 || mach_nodes == 0) begin
          if (mach_nodes > 0 && $urandom_range(0, 9) != 0) nd = $urandom_range(0, mach_nodes - 1);
          else nd = $urandom_range(0, 255);
          set_node(nd, $urandom_range(0, 99) >= busy_pct);
          sent++;
        end else begin
          // sweep one group so group fits start to fail
          base = $urandom_range(0, mach_groups - 1) * grp_nodes;
          for (int l = 0; l < grp_nodes; l++) begin
            set_node(base + l, $urandom_range(0, 99) >= 75);
            sent++;
          end
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
